/* hdl/mfp_pkg.sv */
// Shared types, constants and the CRC8 step for the frame parser.
// No dependencies; the parser, readout and top-level files import this package.
package mfp_pkg;

    // Header bytes
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_V1     = 8'h4D;  // 'M'
    localparam logic [7:0] CH_V2     = 8'h58;  // 'X'
    localparam logic [7:0] CH_REQ    = 8'h3C;  // '<'

    // CRC8 DVB-S2 polynomial
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Header of a frame that checked good, held for readout
    typedef struct packed {
        logic        is_v2;
        logic [7:0]  flags;
        logic [15:0] cmd;
        logic [6:0]  len;
    } t_frame_hdr;

    // One CRC8 byte update, MSB first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/mfp_if.sv */
// Valid/ready channel interfaces: received bytes in, frame readout words out.
// Standalone; no package needed.
interface mfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfp_out_if;
    logic        valid;
    logic        ready;
    logic        is_v2;
    logic [7:0]  frame_flags;
    logic [15:0] command_id;
    logic [6:0]  payload_count;
    logic        byte_present;
    logic [5:0]  byte_position;
    logic [7:0]  payload_value;
    logic        last_of_frame;

    modport source (
        output valid, input ready,
        output is_v2, output frame_flags, output command_id, output payload_count,
        output byte_present, output byte_position, output payload_value,
        output last_of_frame
    );
    modport sink (
        input valid, output ready,
        input is_v2, input frame_flags, input command_id, input payload_count,
        input byte_present, input byte_position, input payload_value,
        input last_of_frame
    );
endinterface

/* hdl/mfp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module mfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mfp_parser.sv */
// Byte-serial header/check state machine; writes payload bytes to the RAM.
// Depends on mfp_pkg and mfp_in_if.
module mfp_parser #(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mfp_in_if.sink              i_in,
    input  logic                i_busy,
    output logic                o_start,
    output mfp_pkg::t_frame_hdr o_hdr,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output logic [7:0]          o_wdata
);
    import mfp_pkg::*;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_HEADER    = 4'd1;
    localparam logic [3:0] PH_DIR       = 4'd2;
    localparam logic [3:0] PH_V1_SIZE   = 4'd3;
    localparam logic [3:0] PH_V1_CMD    = 4'd4;
    localparam logic [3:0] PH_V1_DATA   = 4'd5;
    localparam logic [3:0] PH_V1_CHECK  = 4'd6;
    localparam logic [3:0] PH_V2_FLAGS  = 4'd7;
    localparam logic [3:0] PH_V2_CMD_LO = 4'd8;
    localparam logic [3:0] PH_V2_CMD_HI = 4'd9;
    localparam logic [3:0] PH_V2_LEN_LO = 4'd10;
    localparam logic [3:0] PH_V2_LEN_HI = 4'd11;
    localparam logic [3:0] PH_V2_DATA   = 4'd12;
    localparam logic [3:0] PH_V2_CHECK  = 4'd13;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [3:0]  r_phase, n_phase;
    logic        r_v2, n_v2;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_cmd, n_cmd;
    logic [6:0]  r_len, n_len;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [6:0]  r_fill, n_fill;
    logic [7:0]  r_chk, n_chk;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] len_full;
    logic [6:0]  fill_inc;
    logic [7:0]  crc_in;
    logic [7:0]  crc_out;

    // Input side is blocked while a frame is read out
    assign i_in.ready = !i_busy;
    assign accept     = i_in.valid && !i_busy;
    assign b          = i_in.rx_byte;
    assign len_full   = {b, r_len_lo};
    assign fill_inc   = r_fill + 7'd1;

    // One shared CRC update; the flags byte starts from zero
    assign crc_in  = (r_phase == PH_V2_FLAGS) ? 8'h00 : r_chk;
    assign crc_out = crc8_step(crc_in, b);

    // Next-state logic
    always_comb begin
        n_phase  = r_phase;
        n_v2     = r_v2;
        n_flags  = r_flags;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_len_lo = r_len_lo;
        n_fill   = r_fill;
        n_chk    = r_chk;
        o_start  = 1'b0;
        o_we     = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (b == CH_DOLLAR) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    priority if (b == CH_V1) begin
                        n_v2    = 1'b0;
                        n_phase = PH_DIR;
                    end else if (b == CH_V2) begin
                        n_v2    = 1'b1;
                        n_phase = PH_DIR;
                    end else begin
                        n_phase = PH_IDLE;
                        n_fill  = '0;
                        n_chk   = '0;
                    end
                end
                PH_DIR: begin
                    if (b != CH_REQ) begin
                        n_phase = PH_IDLE;
                        n_fill  = '0;
                        n_chk   = '0;
                    end else begin
                        n_phase = r_v2 ? PH_V2_FLAGS : PH_V1_SIZE;
                    end
                end
                PH_V1_SIZE: begin
                    n_fill = '0;
                    if ({8'h00, b} > MAX_LEN) begin
                        n_phase = PH_IDLE;
                        n_chk   = '0;
                    end else begin
                        n_len   = b[6:0];
                        n_chk   = b;
                        n_phase = PH_V1_CMD;
                    end
                end
                PH_V1_CMD: begin
                    n_cmd   = {8'h00, b};
                    n_flags = '0;
                    n_chk   = r_chk ^ b;
                    n_phase = (r_len == 7'd0) ? PH_V1_CHECK : PH_V1_DATA;
                end
                PH_V1_DATA: begin
                    o_we   = 1'b1;
                    n_fill = fill_inc;
                    n_chk  = r_chk ^ b;
                    if (fill_inc >= r_len) begin
                        n_phase = PH_V1_CHECK;
                    end
                end
                PH_V1_CHECK, PH_V2_CHECK: begin
                    o_start = (b == r_chk);
                    n_phase = PH_IDLE;
                    n_fill  = '0;
                    n_chk   = '0;
                end
                PH_V2_FLAGS: begin
                    n_flags = b;
                    n_chk   = crc_out;
                    n_phase = PH_V2_CMD_LO;
                end
                PH_V2_CMD_LO: begin
                    n_cmd   = {8'h00, b};
                    n_chk   = crc_out;
                    n_phase = PH_V2_CMD_HI;
                end
                PH_V2_CMD_HI: begin
                    n_cmd   = {b, r_cmd[7:0]};
                    n_chk   = crc_out;
                    n_phase = PH_V2_LEN_LO;
                end
                PH_V2_LEN_LO: begin
                    n_len_lo = b;
                    n_chk    = crc_out;
                    n_phase  = PH_V2_LEN_HI;
                end
                PH_V2_LEN_HI: begin
                    n_fill = '0;
                    if (len_full > MAX_LEN) begin
                        n_phase = PH_IDLE;
                        n_chk   = '0;
                    end else begin
                        n_len   = len_full[6:0];
                        n_chk   = crc_out;
                        n_phase = (len_full == 16'd0) ? PH_V2_CHECK : PH_V2_DATA;
                    end
                end
                PH_V2_DATA: begin
                    o_we   = 1'b1;
                    n_fill = fill_inc;
                    n_chk  = crc_out;
                    if (fill_inc >= r_len) begin
                        n_phase = PH_V2_CHECK;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_fill  = '0;
                    n_chk   = '0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_v2     <= 1'b0;
            r_flags  <= '0;
            r_cmd    <= '0;
            r_len    <= '0;
            r_len_lo <= '0;
            r_fill   <= '0;
            r_chk    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_v2     <= n_v2;
            r_flags  <= n_flags;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_len_lo <= n_len_lo;
            r_fill   <= n_fill;
            r_chk    <= n_chk;
        end
    end

    // Payload write port and header handoff
    assign o_waddr     = r_fill[AW-1:0];
    assign o_wdata     = b;
    assign o_hdr.is_v2 = r_v2;
    assign o_hdr.flags = r_flags;
    assign o_hdr.cmd   = r_cmd;
    assign o_hdr.len   = r_len;

endmodule

/* hdl/mfp_readout.sv */
// Frame readout: walks the payload RAM and presents one result word per entry.
// The RAM's read register doubles as the payload byte of the output register.
// Depends on mfp_pkg and mfp_out_if.
module mfp_readout #(
    parameter int AW = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mfp_pkg::t_frame_hdr i_hdr,
    output logic                o_busy,
    output logic                o_re,
    output logic [AW-1:0]       o_raddr,
    input  logic [7:0]          i_rdata,
    mfp_out_if.source           o_out
);
    import mfp_pkg::*;

    logic       r_busy, n_busy;
    logic [6:0] r_k, n_k;
    logic       r_ov, n_ov;
    logic [5:0] r_pos, n_pos;
    logic       r_present, n_present;
    logic       r_last, n_last;

    logic [6:0] count;
    logic       taken;
    logic       issue;

    // An empty payload still gives one result
    assign count = (i_hdr.len == 7'd0) ? 7'd1 : i_hdr.len;
    assign taken = r_ov && o_out.ready;
    assign issue = r_busy && (r_k != count) && (!r_ov || o_out.ready);

    // Read the next entry whenever the output slot is free or being freed
    always_comb begin
        n_busy    = r_busy;
        n_k       = r_k;
        n_ov      = r_ov;
        n_pos     = r_pos;
        n_present = r_present;
        n_last    = r_last;
        priority if (i_start) begin
            n_busy = 1'b1;
            n_k    = '0;
        end else if (issue) begin
            n_ov      = 1'b1;
            n_pos     = r_k[5:0];
            n_present = (i_hdr.len != 7'd0);
            n_last    = ((r_k + 7'd1) == count);
            n_k       = r_k + 7'd1;
        end else if (taken) begin
            n_ov = 1'b0;
            if (r_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_k       <= '0;
            r_ov      <= 1'b0;
            r_pos     <= '0;
            r_present <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_k       <= n_k;
            r_ov      <= n_ov;
            r_pos     <= n_pos;
            r_present <= n_present;
            r_last    <= n_last;
        end
    end

    assign o_busy  = r_busy;
    assign o_re    = issue;
    assign o_raddr = r_k[AW-1:0];

    // Output word; header fields stay stable in the parser during readout
    assign o_out.valid         = r_ov;
    assign o_out.is_v2         = i_hdr.is_v2;
    assign o_out.frame_flags   = i_hdr.flags;
    assign o_out.command_id    = i_hdr.cmd;
    assign o_out.payload_count = i_hdr.len;
    assign o_out.byte_present  = r_present;
    assign o_out.byte_position = r_pos;
    assign o_out.payload_value = r_present ? i_rdata : 8'h00;
    assign o_out.last_of_frame = r_last;

endmodule

/* hdl/msp_frame_parser.sv */
// MSP V1/V2 request frame parser; uses mfp_pkg, mfp_if, mfp_parser, mfp_ram, mfp_readout.
// Takes one byte per cycle while parsing. After a good check byte the readout goes busy
// and starts the registered payload RAM read of the first result word; then one word per
// cycle follows while the sink is ready. N payload bytes give max(N,1) words; the input is
// closed after the check byte until the last word is taken.
// Synchronous active-low reset returns the parser to idle; the payload RAM is not cleared.
module msp_frame_parser #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfp_in_if.sink    i_in,
    mfp_out_if.source o_out
);
    import mfp_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic          start;
    logic          busy;
    t_frame_hdr    hdr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    // Parsing and readout never overlap, so the RAM ports never hit the same entry at once
    mfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_busy  (busy),
        .o_start (start),
        .o_hdr   (hdr),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata)
    );

    mfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mfp_readout #(
        .AW (AW)
    ) u_readout (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_hdr   (hdr),
        .o_busy  (busy),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_out   (o_out)
    );

    // No byte is taken while a result word is pending
    a_no_input_during_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result word is pending");

    // Taking the last word of a frame reopens the input side
    a_reopen_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_frame) |=> i_in.ready)
        else $error("input not reopened after last word");

    // An empty frame is one word with no byte
    a_empty_frame_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_present) |->
            (o_out.last_of_frame && o_out.payload_count == 7'd0
             && o_out.payload_value == 8'h00))
        else $error("bad empty-payload word");

    // A carried byte lies inside the payload
    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.byte_present) |->
            ({1'b0, o_out.byte_position} < o_out.payload_count))
        else $error("byte position beyond payload");

endmodule
